>>> rtl/mqrs_pkg.sv
// Package for the monic quadratic root solver: constants, control types, width helpers.
`timescale 1ns / 1ps

package mqrs_pkg;

	localparam int COEF_WIDTH_DEF = 16;
	localparam int ROOT_W         = 17;
	localparam int BAND_W         = 16;
	localparam int A0_SHIFT       = 10;

	localparam logic [BAND_W-1:0] BAND_RESET = 16'd1;

	// Root count codes
	localparam logic [1:0] CNT_NONE   = 2'd0;
	localparam logic [1:0] CNT_DOUBLE = 2'd1;
	localparam logic [1:0] CNT_TWO    = 2'd2;

	typedef struct packed {
		logic       valid;
		logic [1:0] count;
	} ctl_t;

	// Signed discriminant width: a1^2 next to a0 * 1024, plus one bit of headroom.
	function automatic int disc_width(input int w);
		int prod_w;
		int lin_w;
		prod_w = 2 * w;
		lin_w  = w + A0_SHIFT + 1;
		return ((prod_w > lin_w) ? prod_w : lin_w) + 1;
	endfunction

	// Square root width: half the discriminant, rounded down.
	function automatic int sqrt_width(input int w);
		return disc_width(w) / 2;
	endfunction

	// Width of -a1 +/- s without overflow.
	function automatic int sum_width(input int w);
		int s_w;
		s_w = sqrt_width(w);
		return ((w > s_w) ? w : s_w + 1) + 2;
	endfunction

	function automatic int ext_width(input int w);
		return (sum_width(w) > ROOT_W) ? sum_width(w) : ROOT_W;
	endfunction

endpackage

>>> rtl/mqrs_coef_if.sv
// Coefficient input channel: valid, ready and one coefficient pair.
`timescale 1ns / 1ps

interface mqrs_coef_if #(
	parameter int COEF_WIDTH = mqrs_pkg::COEF_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COEF_WIDTH-1:0] lin_coef;
	logic signed [COEF_WIDTH-1:0] const_coef;

	modport source (output valid, output lin_coef, output const_coef, input ready);
	modport sink   (input valid, input lin_coef, input const_coef, output ready);
endinterface

>>> rtl/mqrs_root_if.sv
// Root output channel: valid, ready, root count and two roots.
`timescale 1ns / 1ps

interface mqrs_root_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         root_count;
	logic signed [mqrs_pkg::ROOT_W-1:0] root_first;
	logic signed [mqrs_pkg::ROOT_W-1:0] root_second;

	modport source (output valid, output root_count, output root_first, output root_second,
		input ready);
	modport sink   (input valid, input root_count, input root_first, input root_second,
		output ready);
endinterface

>>> rtl/mqrs_cfg_if.sv
// Configuration write channel: valid, ready and the zero band value.
`timescale 1ns / 1ps

interface mqrs_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [mqrs_pkg::BAND_W-1:0]  zero_band;

	modport source (output valid, output zero_band, input ready);
	modport sink   (input valid, input zero_band, output ready);
endinterface

>>> rtl/monic_quadratic_root_solver_top.sv
// Top level of the monic quadratic root solver: config register, front stages, root chain.
// Usage:
//   coef_in  takes one item per cycle while ready is high: lin_coef (a1) and const_coef (a0), signed Q8.8.
//   root_out gives one item per input: root_count (0, 1 or 2) and two signed Q9.8 roots,
//            unused roots read zero.
//   cfg_in   writes zero_band (Q16.16 units); it is always ready and should be written
//            only while no item is in flight.
// From accept to result valid an item passes two front stages (square, then discriminant
// and class), one cell per root bit in the square root chain and one output register;
// the first stage loads at the accepting edge.
// Throughput is one item per cycle while the pipeline advances; the root chain resolves one
// bit per cell and every cell hands its partial root to the next on each advancing cycle.
// When the receiver stalls with a result waiting, the whole pipeline holds and coef_in
// drops ready; the pipeline advances whenever the output register is empty or being
// taken, so a new item is accepted in the same cycle the waiting result is taken.
// Reset clears all valid flags and sets zero_band to 1; payload registers are not reset.
`timescale 1ns / 1ps

module monic_quadratic_root_solver_top #(
	parameter int COEF_WIDTH = mqrs_pkg::COEF_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mqrs_coef_if.sink   coef_in,
	mqrs_root_if.source root_out,
	mqrs_cfg_if.sink    cfg_in
);
	localparam int S_W = mqrs_pkg::sqrt_width(COEF_WIDTH);

	logic [mqrs_pkg::BAND_W-1:0] zero_band_q;
	logic                        adv;

	// Chain taps: index 0 is the front stage output, index S_W the last cell.
	mqrs_pkg::ctl_t              ctl_c  [0:S_W];
	logic signed [COEF_WIDTH-1:0] a1_c  [0:S_W];
	logic [2*S_W-1:0]            rad_c  [0:S_W];
	logic [S_W+1:0]              rem_c  [0:S_W];
	logic [S_W-1:0]              root_c [0:S_W];

	// Config register: always ready, write on handshake.
	assign cfg_in.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_band_q <= mqrs_pkg::BAND_RESET;
		end else if (cfg_in.valid) begin
			zero_band_q <= cfg_in.zero_band;
		end
	end

	// Advance everything whenever the output register is empty or being taken.
	assign adv           = !root_out.valid || root_out.ready;
	assign coef_in.ready = adv;

	mqrs_disc #(
		.COEF_WIDTH (COEF_WIDTH)
	) u_disc (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (coef_in.valid),
		.lin_coef   (coef_in.lin_coef),
		.const_coef (coef_in.const_coef),
		.zero_band  (zero_band_q),
		.ctl_s2     (ctl_c[0]),
		.a1_s2      (a1_c[0]),
		.rad_s2     (rad_c[0])
	);

	// Start each square root with an empty remainder and root.
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;

	for (genvar i = 0; i < S_W; i++) begin : g_cell
		mqrs_sqrt_cell #(
			.COEF_WIDTH (COEF_WIDTH)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.ctl    (ctl_c[i]),
			.a1     (a1_c[i]),
			.rad    (rad_c[i]),
			.rem    (rem_c[i]),
			.root   (root_c[i]),
			.ctl_q  (ctl_c[i+1]),
			.a1_q   (a1_c[i+1]),
			.rad_q  (rad_c[i+1]),
			.rem_q  (rem_c[i+1]),
			.root_q (root_c[i+1])
		);
	end

	mqrs_roots #(
		.COEF_WIDTH (COEF_WIDTH)
	) u_roots (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.ctl      (ctl_c[S_W]),
		.a1       (a1_c[S_W]),
		.root     (root_c[S_W]),
		.root_out (root_out)
	);

`ifndef SYNTHESIS
	// A stalled pipeline holds the first cell.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(ctl_c[1]) && $stable(root_c[1]))
		else $error("root chain moved while stalled");

	// A finished square root leaves a remainder of at most twice the root.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_c[S_W].valid |-> (rem_c[S_W] <= {1'b0, root_c[S_W], 1'b0}))
		else $error("square root remainder out of bound");

	// Every radicand bit has been consumed at the end of the chain.
	a_rad_spent: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_c[S_W].valid |-> (rad_c[S_W] == '0))
		else $error("radicand not fully consumed");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		root_out.valid && (root_out.root_count == mqrs_pkg::CNT_NONE)
		|-> (root_out.root_first == '0) && (root_out.root_second == '0))
		else $error("roots not zero with no real root");

	a_double_zero: assert property (@(posedge clk) disable iff (!arst_n)
		root_out.valid && (root_out.root_count == mqrs_pkg::CNT_DOUBLE)
		|-> (root_out.root_second == '0))
		else $error("second root not zero for a double root");
`endif

endmodule

>>> rtl/mqrs_disc.sv
// Front stages: square the linear coefficient, form and classify the discriminant.
`timescale 1ns / 1ps

module mqrs_disc #(
	parameter int COEF_WIDTH = mqrs_pkg::COEF_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic                             in_valid,
	input  logic signed [COEF_WIDTH-1:0]     lin_coef,
	input  logic signed [COEF_WIDTH-1:0]     const_coef,
	input  logic [mqrs_pkg::BAND_W-1:0]      zero_band,
	output mqrs_pkg::ctl_t                   ctl_s2,
	output logic signed [COEF_WIDTH-1:0]     a1_s2,
	output logic [2*mqrs_pkg::sqrt_width(COEF_WIDTH)-1:0] rad_s2
);
	localparam int D_W = mqrs_pkg::disc_width(COEF_WIDTH);
	localparam int S_W = mqrs_pkg::sqrt_width(COEF_WIDTH);
	localparam int P_W = 2 * COEF_WIDTH;

	logic                         valid_s1;
	logic signed [COEF_WIDTH-1:0] a1_s1;
	logic signed [COEF_WIDTH-1:0] a0_s1;
	logic signed [P_W-1:0]        sq_s1;

	logic signed [D_W-1:0] disc;
	logic [D_W-1:0]        mag;
	logic [1:0]            count;
	logic [2*S_W-1:0]      rad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			ctl_s2      <= '0;
		end else if (adv) begin
			valid_s1    <= in_valid;
			ctl_s2      <= '{valid: valid_s1, count: count};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a1_s1  <= lin_coef;
			a0_s1  <= const_coef;
			sq_s1  <= P_W'(lin_coef) * P_W'(lin_coef);
			a1_s2  <= a1_s1;
			rad_s2 <= rad;
		end
	end

	assign disc = D_W'(sq_s1) - (D_W'(a0_s1) <<< mqrs_pkg::A0_SHIFT);
	assign mag  = disc[D_W-1] ? $unsigned(-disc) : $unsigned(disc);

	always_comb begin
		priority if (mag < D_W'(zero_band)) begin
			count = mqrs_pkg::CNT_DOUBLE;
		end else if (!disc[D_W-1] && (disc != '0)) begin
			count = mqrs_pkg::CNT_TWO;
		end else begin
			count = mqrs_pkg::CNT_NONE;
		end
	end

	// Only a positive discriminant enters the root chain.
	assign rad = (count == mqrs_pkg::CNT_TWO) ? (2*S_W)'($unsigned(disc)) : '0;

endmodule

>>> rtl/mqrs_sqrt_cell.sv
// One square root cell: resolve one root bit from the next two radicand bits.
`timescale 1ns / 1ps

module mqrs_sqrt_cell #(
	parameter int COEF_WIDTH = mqrs_pkg::COEF_WIDTH_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          adv,
	input  mqrs_pkg::ctl_t                                ctl,
	input  logic signed [COEF_WIDTH-1:0]                  a1,
	input  logic [2*mqrs_pkg::sqrt_width(COEF_WIDTH)-1:0] rad,
	input  logic [mqrs_pkg::sqrt_width(COEF_WIDTH)+1:0]   rem,
	input  logic [mqrs_pkg::sqrt_width(COEF_WIDTH)-1:0]   root,
	output mqrs_pkg::ctl_t                                ctl_q,
	output logic signed [COEF_WIDTH-1:0]                  a1_q,
	output logic [2*mqrs_pkg::sqrt_width(COEF_WIDTH)-1:0] rad_q,
	output logic [mqrs_pkg::sqrt_width(COEF_WIDTH)+1:0]   rem_q,
	output logic [mqrs_pkg::sqrt_width(COEF_WIDTH)-1:0]   root_q
);
	localparam int S_W = mqrs_pkg::sqrt_width(COEF_WIDTH);

	logic [S_W+1:0] part;
	logic [S_W+1:0] trial;
	logic           fits;

	// Bring down two bits, try appending a one to the partial root.
	assign part  = {rem[S_W-1:0], rad[2*S_W-1 -: 2]};
	assign trial = {root, 2'b01};
	assign fits  = (part >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a1_q   <= a1;
			rad_q  <= {rad[2*S_W-3:0], 2'b00};
			rem_q  <= fits ? (part - trial) : part;
			root_q <= {root[S_W-2:0], fits};
		end
	end

endmodule

>>> rtl/mqrs_roots.sv
// Output stage: form the roots from -a1 and the square root, hold them for the receiver.
`timescale 1ns / 1ps

module mqrs_roots #(
	parameter int COEF_WIDTH = mqrs_pkg::COEF_WIDTH_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        adv,
	input  mqrs_pkg::ctl_t                              ctl,
	input  logic signed [COEF_WIDTH-1:0]                a1,
	input  logic [mqrs_pkg::sqrt_width(COEF_WIDTH)-1:0] root,
	mqrs_root_if.source                                 root_out
);
	localparam int SUM_W  = mqrs_pkg::sum_width(COEF_WIDTH);
	localparam int EXT_W  = mqrs_pkg::ext_width(COEF_WIDTH);
	localparam int ROOT_W = mqrs_pkg::ROOT_W;

	logic signed [SUM_W-1:0]  neg_a1;
	logic signed [SUM_W-1:0]  sqv;
	logic signed [SUM_W-1:0]  hi_sum;
	logic signed [SUM_W-1:0]  lo_sum;
	logic signed [SUM_W-1:0]  hi_half;
	logic signed [SUM_W-1:0]  lo_half;
	logic signed [SUM_W-1:0]  dbl_half;
	logic signed [EXT_W-1:0]  hi_ext;
	logic signed [EXT_W-1:0]  lo_ext;
	logic signed [EXT_W-1:0]  dbl_ext;
	logic signed [ROOT_W-1:0] first_d;
	logic signed [ROOT_W-1:0] second_d;

	logic                     out_valid_q;
	logic [1:0]               count_q;
	logic signed [ROOT_W-1:0] first_q;
	logic signed [ROOT_W-1:0] second_q;

	assign neg_a1   = -SUM_W'(a1);
	assign sqv      = SUM_W'($signed({1'b0, root}));
	assign hi_sum   = neg_a1 + sqv;
	assign lo_sum   = neg_a1 - sqv;
	// Arithmetic shifts floor the halving.
	assign hi_half  = hi_sum >>> 1;
	assign lo_half  = lo_sum >>> 1;
	assign dbl_half = neg_a1 >>> 1;
	assign hi_ext   = EXT_W'(hi_half);
	assign lo_ext   = EXT_W'(lo_half);
	assign dbl_ext  = EXT_W'(dbl_half);

	always_comb begin
		unique case (ctl.count)
			mqrs_pkg::CNT_TWO: begin
				first_d  = hi_ext[ROOT_W-1:0];
				second_d = lo_ext[ROOT_W-1:0];
			end
			mqrs_pkg::CNT_DOUBLE: begin
				first_d  = dbl_ext[ROOT_W-1:0];
				second_d = '0;
			end
			default: begin
				first_d  = '0;
				second_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			count_q  <= ctl.count;
			first_q  <= first_d;
			second_q <= second_d;
		end
	end

	assign root_out.valid       = out_valid_q;
	assign root_out.root_count  = count_q;
	assign root_out.root_first  = first_q;
	assign root_out.root_second = second_q;

endmodule

>>> verif/monic_quadratic_root_solver_top_tb.sv
// Testbench for the monic quadratic root solver: directed and random pairs, scoreboard.
`timescale 1ns / 1ps

module monic_quadratic_root_solver_top_tb;

	localparam int CW           = mqrs_pkg::COEF_WIDTH_DEF;
	// Leave margin on top of the accept-to-result latency at this width.
	localparam int SETTLE_CYCLES = 30;
	// Slowest correct run: ~470 items, each waiting out long receiver stalls at 74 percent
	// idle plus sender gaps, drains between phases; take that several times over.
	localparam int LIMIT_CYCLES  = 400000;

	typedef struct packed {
		logic [1:0]                         count;
		logic signed [mqrs_pkg::ROOT_W-1:0] first;
		logic signed [mqrs_pkg::ROOT_W-1:0] second;
	} root_set_t;

	logic clk;
	logic arst_n;

	mqrs_coef_if #(.COEF_WIDTH(CW)) coef_ch ();
	mqrs_root_if                    root_ch ();
	mqrs_cfg_if                     cfg_ch ();

	monic_quadratic_root_solver_top #(
		.COEF_WIDTH(CW)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.coef_in (coef_ch),
		.root_out(root_ch),
		.cfg_in  (cfg_ch)
	);

	// Expected root sets, oldest first, and the band the predictor applies.
	root_set_t   root_expect_q[$];
	logic [15:0] band_model;

	int send_idle_pct;
	int recv_idle_pct;
	int error_count;
	int cycle_count;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Floor of the square root, one result bit at a time from the top.
	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = 20; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v) begin
				root = trial;
			end
		end
		return root;
	endfunction

	// Classify the discriminant and form the roots; every halving floors.
	function automatic root_set_t predict_roots(input logic signed [CW-1:0] a1,
		input logic signed [CW-1:0] a0, input logic [15:0] band);
		longint          neg_a1;
		longint          disc;
		longint          s;
		longint          r1;
		longint          r2;
		longint unsigned mag;
		root_set_t       r;
		neg_a1 = -longint'(a1);
		disc   = longint'(a1) * longint'(a1) - longint'(a0) * 1024;
		mag    = (disc < 0) ? longint'(-disc) : disc;
		r1     = 0;
		r2     = 0;
		if (mag < longint'(band)) begin
			r.count = mqrs_pkg::CNT_DOUBLE;
			r1      = neg_a1 >>> 1;
		end else if (disc > 0) begin
			s       = longint'(floor_sqrt(disc));
			r.count = mqrs_pkg::CNT_TWO;
			r1      = (neg_a1 + s) >>> 1;
			r2      = (neg_a1 - s) >>> 1;
		end else begin
			r.count = mqrs_pkg::CNT_NONE;
		end
		r.first  = r1[mqrs_pkg::ROOT_W-1:0];
		r.second = r2[mqrs_pkg::ROOT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		error_count++;
	endtask

	// Drive one coefficient pair, with a random gap first, and hold until accepted.
	// Valid stays high after acceptance so back-to-back items need no toggle.
	task automatic send_coef_pair(input logic signed [CW-1:0] a1, input logic signed [CW-1:0] a0);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			coef_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		coef_ch.valid      <= 1'b1;
		coef_ch.lin_coef   <= a1;
		coef_ch.const_coef <= a0;
		do begin
			@(posedge clk);
		end while (!coef_ch.ready);
	endtask

	// Drop valid and wait until every expected item has come back, then let the pipe settle.
	task automatic wait_pipeline_empty();
		coef_ch.valid <= 1'b0;
		// Let the predictor record an item taken at the last edge.
		@(posedge clk);
		while (root_expect_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_zero_band(input logic [15:0] band);
		wait_pipeline_empty();
		cfg_ch.valid     <= 1'b1;
		cfg_ch.zero_band <= band;
		do begin
			@(posedge clk);
		end while (!cfg_ch.ready);
		band_model   = band;
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Reset band of 1: field extremes, exact zero discriminant, odd halving of negatives.
	task automatic test_coef_extremes();
		send_coef_pair(16'sh8000, 16'sh8000);
		send_coef_pair(16'sh7fff, 16'sh7fff);
		send_coef_pair(16'sh7fff, 16'sh8000);
		send_coef_pair(16'sh8000, 16'sh0000);
		send_coef_pair(16'sh8000, 16'sh7fff);
		send_coef_pair(16'sh0000, 16'sh0000);
		send_coef_pair(16'sh0200, 16'sh0100);   // (x + 1)^2: double root
		send_coef_pair(-16'sh0200, 16'sh0100);  // (x - 1)^2
		send_coef_pair(16'sh0001, 16'sh0000);   // d = 1: just outside the band
		send_coef_pair(16'sh0003, 16'shffff);   // odd negative sum floors down
		send_coef_pair(-16'sh0003, 16'shffff);
		send_coef_pair(16'sh0000, 16'sh0001);   // small negative discriminant: no root
		send_coef_pair(16'shffff, 16'shffff);
	endtask

	// Band of zero: nothing counts as zero, so an exact square gives no root.
	task automatic test_zero_band_off();
		write_zero_band(16'd0);
		send_coef_pair(16'sh0000, 16'sh0000);
		send_coef_pair(16'sh0200, 16'sh0100);
		send_coef_pair(16'sh0001, 16'sh0000);
		send_coef_pair(16'sh0000, 16'sh0001);
	endtask

	// Widest band: probe both edges on the positive and the negative side.
	task automatic test_zero_band_max();
		write_zero_band(16'hffff);
		send_coef_pair(16'sh00ff, 16'sh0000);   // d = 65025: inside
		send_coef_pair(16'sh0100, 16'sh0000);   // d = 65536: outside, two roots
		send_coef_pair(16'sh0000, 16'sh003f);   // d = -64512: inside
		send_coef_pair(16'sh0000, 16'sh0040);   // d = -65536: outside, none
		send_coef_pair(-16'sh00ff, 16'sh0000);
	endtask

	function automatic logic [15:0] pick_band();
		unique case ($urandom_range(3))
			0: begin
				return 16'($urandom_range(16));
			end
			1: begin
				return 16'($urandom_range(1023));
			end
			2: begin
				return 16'($urandom_range(65535, 1024));
			end
			default: begin
				return 16'($urandom_range(65535));
			end
		endcase
	endfunction

	// About four in ten pairs have a discriminant near zero, around the band edge; the rest is
	// full-range noise and small values.
	task automatic send_random_pair(input logic [15:0] band);
		int     a1;
		int     a0;
		int     off;
		int     span;
		int     sel;
		sel = $urandom_range(9);
		if (sel < 4) begin
			a1 = $signed($urandom_range(11584)) - 5792;
			if ($urandom_range(1)) begin
				a1 = (a1 / 32) * 32;   // a1^2 is then a multiple of 1024
			end
			span = band / 1024 + 2;
			off  = $signed($urandom_range(2 * span)) - span;
			a0   = ((a1 * a1) >>> 10) + off;
			if (a0 > 32767) a0 = 32767;
			if (a0 < -32768) a0 = -32768;
		end else if (sel < 8) begin
			a1 = $urandom_range(65535);
			a0 = $urandom_range(65535);
		end else begin
			a1 = $signed($urandom_range(64)) - 32;
			a0 = $signed($urandom_range(64)) - 32;
		end
		send_coef_pair(a1[CW-1:0], a0[CW-1:0]);
	endtask

	// Two band settings per idling pattern, half the items under each.
	task automatic test_random_traffic(input int items, input int s_pct, input int r_pct);
		logic [15:0] band;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int half = 0; half < 2; half++) begin
			band = pick_band();
			write_zero_band(band);
			for (int i = 0; i < items / 2; i++) begin
				send_random_pair(band);
			end
		end
	endtask

	// Receiver: stall at random by the current idle share.
	always @(posedge clk) begin
		root_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Predict at every accepted input item.
	always @(posedge clk) begin
		if (arst_n && coef_ch.valid && coef_ch.ready) begin
			root_expect_q.push_back(predict_roots(coef_ch.lin_coef, coef_ch.const_coef,
				band_model));
		end
	end

	// Compare every accepted result with the oldest prediction.
	always @(posedge clk) begin
		root_set_t want;
		if (arst_n && root_ch.valid && root_ch.ready) begin
			if (root_expect_q.size() == 0) begin
				report_mismatch("unexpected result, count", root_ch.root_count, -1);
			end else begin
				want = root_expect_q.pop_front();
				if (root_ch.root_count !== want.count) begin
					report_mismatch("root_count", root_ch.root_count, want.count);
				end
				if (root_ch.root_first !== want.first) begin
					report_mismatch("root_first", root_ch.root_first, want.first);
				end
				if (root_ch.root_second !== want.second) begin
					report_mismatch("root_second", root_ch.root_second, want.second);
				end
			end
		end
	end

	// Hard stop if the run hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[monic_quadratic_root_solver_top] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n             = 1'b0;
		coef_ch.valid      = 1'b0;
		coef_ch.lin_coef   = '0;
		coef_ch.const_coef = '0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.zero_band   = '0;
		root_ch.ready      = 1'b0;
		band_model         = mqrs_pkg::BAND_RESET;
		send_idle_pct      = 0;
		recv_idle_pct      = 0;
		error_count        = 0;
		cycle_count        = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_coef_extremes();
		test_zero_band_off();
		test_zero_band_max();
		test_random_traffic(150, 25, 74);
		test_random_traffic(150, 74, 25);
		test_random_traffic(150, 0, 0);

		// Drain, then watch for stray results before the verdict.
		wait_pipeline_empty();
		if (error_count == 0) begin
			$display("[monic_quadratic_root_solver_top] OK");
		end else begin
			$display("[monic_quadratic_root_solver_top] ERROR");
		end
		$finish;
	end

endmodule
